>>> hdl/bounded_integer_set_core_defines.svh
// ----------------------------------------------------------------------------
// Bounded integer set: assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off while in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_INTEGER_SET_CORE_DEFINES_SVH
`define BOUNDED_INTEGER_SET_CORE_DEFINES_SVH

// same-cycle implication
`define BIS_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// next-cycle implication
`define BIS_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`endif

>>> hdl/bis_pkg.sv
// ----------------------------------------------------------------------------
// Bounded integer set: package
// Field widths, operation codes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bis_pkg;

  localparam int unsigned OpW    = 2;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [OpW-1:0] {
    OP_TEST   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_e;

endpackage

>>> hdl/bis_if.sv
// ----------------------------------------------------------------------------
// Bounded integer set: channel interfaces
// Request channel (operation, value) and response channel (status, count).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bis_in_if;
  logic                                valid;
  logic                                ready;
  logic [bis_pkg::OpW-1:0]             operation;
  logic signed [bis_pkg::ValueW-1:0]   value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface bis_out_if;
  logic                        valid;
  logic                        ready;
  logic                        was_present;
  logic [bis_pkg::CountW-1:0]  count;
  logic                        is_empty;
  logic                        rejected;

  modport source (output valid, output was_present, output count, output is_empty,
                  output rejected, input ready);
  modport sink   (input valid, input was_present, input count, input is_empty,
                  input rejected, output ready);
endinterface

>>> hdl/bounded_integer_set_core.sv
// ----------------------------------------------------------------------------
// Bounded integer set core
// Set of up to CAPACITY distinct 32-bit values kept in insertion order.
//
// Channels: req_i carries one transaction per operation (test, add, remove)
// with its value; rsp_o returns one transaction per request: was_present,
// count after the operation (mod 32), is_empty and rejected. Both use
// valid/ready; a transaction moves when both are high.
// Sequencing: one request is handled at a time. The sequencer scans the entry
// store one entry per cycle through its single read port and stops at the
// first hit; a miss answers once every entry below the count is read. A remove
// that hits goes on from the hit and moves the later entries down one place
// per cycle through the same port before it answers. The next request is
// accepted in the cycle after the response is loaded.
// Reset: the set is empty; the store is not cleared, only entries below the
// count are ever read.
// Stall: the finished response sits in an output register; a new request is
// accepted meanwhile, and the next response waits until that one is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bounded_integer_set_core_defines.svh"

module bounded_integer_set_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bis_in_if.sink     req_i,
  bis_out_if.source  rsp_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [bis_pkg::CountW-1:0] FullCount = bis_pkg::CountW'(CAPACITY);

  bis_pkg::state_e            state_q, state_d;
  bis_pkg::op_e               op_q;
  logic [bis_pkg::ValueW-1:0] value_q;
  logic [CW-1:0]              occ_q, occ_d;
  logic [CW-1:0]              idx_q, idx_d;
  logic [CW-1:0]              pidx_q, pidx_d;
  logic                       pend_q, pend_d;
  logic                       present_q, present_d;
  logic                       rej_q, rej_d;

  logic                       out_vld_q, out_vld_d;
  logic                       out_load;
  logic                       out_present_q;
  logic [bis_pkg::CountW-1:0] out_count_q;
  logic                       out_empty_q;
  logic                       out_rej_q;

  logic                       accept;
  logic                       hit;
  logic                       scan_or_shift;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [bis_pkg::ValueW-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [bis_pkg::ValueW-1:0] mem_rdata;

  bis_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign req_i.ready   = (state_q == bis_pkg::ST_IDLE);
  assign accept        = req_i.valid && req_i.ready;
  assign hit           = pend_q && (mem_rdata == value_q);
  assign scan_or_shift = (state_q == bis_pkg::ST_SCAN) || (state_q == bis_pkg::ST_SHIFT);

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    idx_d     = idx_q;
    pidx_d    = pidx_q;
    pend_d    = 1'b0;
    present_d = present_q;
    rej_d     = rej_q;
    mem_we    = 1'b0;
    mem_waddr = occ_q[AW-1:0];
    mem_wdata = value_q;
    mem_re    = 1'b0;
    mem_raddr = idx_q[AW-1:0];
    out_load  = 1'b0;
    out_vld_d = out_vld_q && !rsp_o.ready;

    case (state_q)
      bis_pkg::ST_IDLE: begin
        if (accept) begin
          idx_d     = '0;
          present_d = 1'b0;
          rej_d     = 1'b0;
          state_d   = bis_pkg::ST_SCAN;
        end
      end
      bis_pkg::ST_SCAN: begin
        if (hit) begin
          present_d = 1'b1;
          if (op_q == bis_pkg::OP_REMOVE) begin
            idx_d   = pidx_q + CW'(1);
            state_d = bis_pkg::ST_SHIFT;
          end else begin
            state_d = bis_pkg::ST_RESP;
          end
        end else if (idx_q != occ_q) begin
          mem_re = 1'b1;
          idx_d  = idx_q + CW'(1);
          pidx_d = idx_q;
          pend_d = 1'b1;
        end else if (!pend_q) begin
          // value absent
          if (op_q == bis_pkg::OP_ADD) begin
            if (occ_q != CW'(CAPACITY)) begin
              mem_we = 1'b1;
              occ_d  = occ_q + CW'(1);
            end else begin
              rej_d = 1'b1;
            end
          end
          state_d = bis_pkg::ST_RESP;
        end
      end
      bis_pkg::ST_SHIFT: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(pidx_q - CW'(1));
          mem_wdata = mem_rdata;
        end
        if (idx_q != occ_q) begin
          mem_re = 1'b1;
          idx_d  = idx_q + CW'(1);
          pidx_d = idx_q;
          pend_d = 1'b1;
        end else if (!pend_q) begin
          occ_d   = occ_q - CW'(1);
          state_d = bis_pkg::ST_RESP;
        end
      end
      bis_pkg::ST_RESP: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = bis_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bis_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bis_pkg::ST_IDLE;
      occ_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    pidx_q    <= pidx_d;
    present_q <= present_d;
    rej_q     <= rej_d;
    if (accept) begin
      op_q    <= bis_pkg::op_e'(req_i.operation);
      value_q <= req_i.value;
    end
    if (out_load) begin
      out_present_q <= present_q;
      out_count_q   <= bis_pkg::CountW'(occ_q);
      out_empty_q   <= (occ_q == '0);
      out_rej_q     <= rej_q;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.was_present = out_present_q;
  assign rsp_o.count       = out_count_q;
  assign rsp_o.is_empty    = out_empty_q;
  assign rsp_o.rejected    = out_rej_q;

  `BIS_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= CW'(CAPACITY), "occupancy above capacity")
  `BIS_ASSERT_NEXT(a_occ_idle_hold, req_i.ready, occ_q == $past(occ_q), "occupancy moved idle")
  `BIS_ASSERT_IMP(a_no_write_idle, !scan_or_shift, !mem_we, "store written outside scan or shift")
  `BIS_ASSERT_IMP(a_reject_full, out_vld_q && out_rej_q, out_count_q == FullCount, "reject not full")

endmodule

>>> hdl/bis_store.sv
// ----------------------------------------------------------------------------
// Bounded integer set: entry store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bis_store #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [$clog2(DEPTH)-1:0]          waddr_i,
  input  logic [bis_pkg::ValueW-1:0]        wdata_i,
  input  logic                              re_i,
  input  logic [$clog2(DEPTH)-1:0]          raddr_i,
  output logic [bis_pkg::ValueW-1:0]        rdata_o
);

  logic [bis_pkg::ValueW-1:0] mem_q [DEPTH];
  logic [bis_pkg::ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
